@@ design/bdu_pkg.sv @@
package bdu_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int TARGET_GRID = 100;
  localparam int MAX_SIDE    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int BLOCK_LIMIT = 200;

  localparam int SIZE_W = 11;  // frame size register
  localparam int POS_W  = 10;  // pixel position
  localparam int SUB_W  = 4;   // position inside a block
  localparam int BLK_W  = 8;   // block index
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 16;
  localparam int CNT_W  = 9;   // pixels per block, up to 10*10
  localparam int IDX_W  = $clog2(BLOCK_LIMIT);

  localparam int QUEUE_DEPTH = 4;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_FRAME_ROWS = 1'b0;
  localparam logic [0:0] REG_FRAME_COLS = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TARGET_GRID);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADD,
    BK_DIV,
    BK_HOLD
  } bdu_back_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [BLK_W-1:0] blk_col;
    logic [BLK_W-1:0] blk_row;
    logic [CNT_W-1:0] count;
    logic             first;
    logic             emit;
    logic             frame_end;
  } bdu_cmd_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_W'(TARGET_GRID)) r = SIZE_W'(TARGET_GRID);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // Block size: count the multiples of the grid that the clamped size reaches.
  function automatic logic [SUB_W-1:0] block_size(input logic [SIZE_W-1:0] v);
    logic [SUB_W-1:0] n;
    n = '0;
    for (int k = 1; k <= MAX_SIDE / TARGET_GRID; k++) begin
      if ({1'b0, v} >= (SIZE_W + 1)'(k * TARGET_GRID)) n = n + 1'b1;
    end
    return n;
  endfunction

  function automatic logic [BLK_W-1:0] sat_block(input logic [BLK_W-1:0] v);
    logic [BLK_W:0] nxt;
    nxt = {1'b0, v} + 1'b1;
    return (nxt >= (BLK_W + 1)'(BLOCK_LIMIT)) ? BLK_W'(BLOCK_LIMIT - 1) : nxt[BLK_W-1:0];
  endfunction

endpackage

@@ design/bdu_if.sv @@
interface bdu_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [bdu_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bdu_result_if;
  logic                     valid;
  logic                     ready;
  logic [bdu_pkg::PIX_W-1:0] average;
  logic [bdu_pkg::BLK_W-1:0] out_row;
  logic [bdu_pkg::BLK_W-1:0] out_col;
  logic                     frame_end;

  modport source (output valid, output average, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink (input valid, input average, input out_row, input out_col,
                input frame_end, output ready);
endinterface

@@ design/bdu_front.sv @@
module bdu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bdu_pixel_if.sink                     pix,
  input  logic [bdu_pkg::SIZE_W-1:0]    frame_rows_i,
  input  logic [bdu_pkg::SIZE_W-1:0]    frame_cols_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output bdu_pkg::bdu_cmd_t             cmd_o
);

  logic [bdu_pkg::POS_W-1:0]  pix_col_q, pix_col_d;
  logic [bdu_pkg::POS_W-1:0]  pix_row_q, pix_row_d;
  logic [bdu_pkg::SUB_W-1:0]  sub_row_q, sub_row_d;
  logic [bdu_pkg::SUB_W-1:0]  sub_col_q, sub_col_d;
  logic [bdu_pkg::BLK_W-1:0]  blk_col_q, blk_col_d;
  logic [bdu_pkg::BLK_W-1:0]  blk_row_q, blk_row_d;

  logic [bdu_pkg::SIZE_W-1:0] rows, cols;
  logic [bdu_pkg::SUB_W-1:0]  blk_h, blk_w;
  logic                       row_edge, col_edge, rblock_end, cblock_end;
  logic [bdu_pkg::SUB_W:0]    sub_row_n, sub_col_n;
  logic [2*bdu_pkg::SUB_W+1:0] count_full;

  assign rows  = bdu_pkg::clamp_size(frame_rows_i, bdu_pkg::SIZE_W'(bdu_pkg::MAX_HEIGHT));
  assign cols  = bdu_pkg::clamp_size(frame_cols_i, bdu_pkg::SIZE_W'(bdu_pkg::MAX_WIDTH));
  assign blk_h = bdu_pkg::block_size(rows);
  assign blk_w = bdu_pkg::block_size(cols);

  assign row_edge   = {1'b0, pix_row_q} >= (rows - 1'b1);
  assign col_edge   = {1'b0, pix_col_q} >= (cols - 1'b1);
  assign rblock_end = row_edge || (sub_row_q >= blk_h - 1'b1);
  assign cblock_end = col_edge || (sub_col_q >= blk_w - 1'b1);

  assign sub_row_n  = {1'b0, sub_row_q} + 1'b1;
  assign sub_col_n  = {1'b0, sub_col_q} + 1'b1;
  assign count_full = sub_row_n * sub_col_n;

  assign pix.ready = !q_full_i;
  assign push_o    = pix.valid && pix.ready;

  always_comb begin
    cmd_o.pixel     = pix.pixel;
    cmd_o.blk_col   = blk_col_q;
    cmd_o.blk_row   = blk_row_q;
    cmd_o.count     = count_full[bdu_pkg::CNT_W-1:0];
    cmd_o.first     = (sub_row_q == '0) && (sub_col_q == '0);
    cmd_o.emit      = rblock_end && cblock_end;
    cmd_o.frame_end = row_edge && col_edge;
  end

  always_comb begin
    pix_col_d = pix_col_q;
    pix_row_d = pix_row_q;
    sub_row_d = sub_row_q;
    sub_col_d = sub_col_q;
    blk_col_d = blk_col_q;
    blk_row_d = blk_row_q;
    if (push_o) begin
      if (col_edge) begin
        pix_col_d = '0;
        sub_col_d = '0;
        blk_col_d = '0;
        if (row_edge) begin
          pix_row_d = '0;
          sub_row_d = '0;
          blk_row_d = '0;
        end else begin
          pix_row_d = pix_row_q + 1'b1;
          if (rblock_end) begin
            sub_row_d = '0;
            blk_row_d = bdu_pkg::sat_block(blk_row_q);
          end else begin
            sub_row_d = sub_row_q + 1'b1;
          end
        end
      end else begin
        pix_col_d = pix_col_q + 1'b1;
        if (cblock_end) begin
          sub_col_d = '0;
          blk_col_d = bdu_pkg::sat_block(blk_col_q);
        end else begin
          sub_col_d = sub_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_col_q <= '0;
      pix_row_q <= '0;
      sub_row_q <= '0;
      sub_col_q <= '0;
      blk_col_q <= '0;
      blk_row_q <= '0;
    end else begin
      pix_col_q <= pix_col_d;
      pix_row_q <= pix_row_d;
      sub_row_q <= sub_row_d;
      sub_col_q <= sub_col_d;
      blk_col_q <= blk_col_d;
      blk_row_q <= blk_row_d;
    end
  end

  a_frame_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd_o.frame_end) |-> cmd_o.emit)
    else $error("frame end flagged on a pixel that closes no block");

endmodule

@@ design/bdu_fifo.sv @@
module bdu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bdu_pkg::bdu_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bdu_pkg::bdu_cmd_t cmd_o
);

  localparam int PTR_W = (bdu_pkg::QUEUE_DEPTH > 1) ? $clog2(bdu_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bdu_pkg::QUEUE_DEPTH + 1);

  bdu_pkg::bdu_cmd_t  slot_q [bdu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(bdu_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(bdu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(bdu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue read while empty");

endmodule

@@ design/bdu_div.sv @@
module bdu_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bdu_pkg::SUM_W-1:0]  dividend_i,
  input  logic [bdu_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [bdu_pkg::SUM_W-1:0]  quotient_o
);

  localparam int STEP_W = $clog2(bdu_pkg::SUM_W);

  logic                        busy_q, done_q;
  logic [STEP_W-1:0]           step_q;
  logic [bdu_pkg::SUM_W-1:0]   quo_q;
  logic [bdu_pkg::CNT_W-1:0]   rem_q;
  logic [bdu_pkg::CNT_W-1:0]   den_q;
  logic [bdu_pkg::CNT_W:0]     trial;
  logic [bdu_pkg::CNT_W:0]     diff;
  logic                        take;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, quo_q[bdu_pkg::SUM_W-1]};
  assign take  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(bdu_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[bdu_pkg::SUM_W-2:0], take};
      rem_q <= take ? diff[bdu_pkg::CNT_W-1:0] : trial[bdu_pkg::CNT_W-1:0];
    end
  end

endmodule

@@ design/bdu_back.sv @@
module bdu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  bdu_pkg::bdu_cmd_t cmd_i,
  output logic              cmd_pop_o,
  bdu_result_if.source      res
);

  bdu_pkg::bdu_back_e         state_q, state_d;
  bdu_pkg::bdu_cmd_t          cmd_q;
  logic [bdu_pkg::SUM_W-1:0]  sums [bdu_pkg::BLOCK_LIMIT];
  logic [bdu_pkg::SUM_W-1:0]  rdata_q;
  logic [bdu_pkg::SUM_W-1:0]  sum;
  logic                       mem_we;
  logic                       div_start, div_done;
  logic [bdu_pkg::SUM_W-1:0]  quotient;
  logic                       res_free, res_load;
  logic                       res_valid_q;
  logic [bdu_pkg::PIX_W-1:0]  avg_q;
  logic [bdu_pkg::BLK_W-1:0]  row_q, col_q;
  logic                       fend_q;

  assign sum = cmd_q.first ? bdu_pkg::SUM_W'(cmd_q.pixel)
                           : rdata_q + bdu_pkg::SUM_W'(cmd_q.pixel);
  assign res_free = !res_valid_q || res.ready;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      bdu_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = bdu_pkg::BK_ADD;
        end
      end
      bdu_pkg::BK_ADD: begin
        mem_we = 1'b1;
        if (cmd_q.emit) begin
          div_start = 1'b1;
          state_d   = bdu_pkg::BK_DIV;
        end else begin
          state_d = bdu_pkg::BK_IDLE;
        end
      end
      bdu_pkg::BK_DIV: begin
        if (div_done) state_d = bdu_pkg::BK_HOLD;
      end
      bdu_pkg::BK_HOLD: begin
        if (res_free) begin
          res_load = 1'b1;
          state_d  = bdu_pkg::BK_IDLE;
        end
      end
      default: state_d = bdu_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdu_pkg::BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) res_valid_q <= 1'b1;
      else if (res.ready) res_valid_q <= 1'b0;
    end
  end

  // Column sum memory: read on pop, write back in the next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q   <= cmd_i;
      rdata_q <= sums[cmd_i.blk_col[bdu_pkg::IDX_W-1:0]];
    end
    if (mem_we) sums[cmd_q.blk_col[bdu_pkg::IDX_W-1:0]] <= sum;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      avg_q  <= (|quotient[bdu_pkg::SUM_W-1:bdu_pkg::PIX_W]) ? '1
                                                            : quotient[bdu_pkg::PIX_W-1:0];
      row_q  <= cmd_q.blk_row;
      col_q  <= cmd_q.blk_col;
      fend_q <= cmd_q.frame_end;
    end
  end

  assign res.valid     = res_valid_q;
  assign res.average   = avg_q;
  assign res.out_row   = row_q;
  assign res.out_col   = col_q;
  assign res.frame_end = fend_q;

  bdu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (cmd_q.count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == bdu_pkg::BK_DIV))
    else $error("divider finished outside the divide state");

endmodule

@@ design/block_average_downscaler_unit.sv @@
// Channel   Direction  Handshake      Payload
// pix_i     in         valid/ready    pixel[7:0]
// res_o     out        valid/ready    average[7:0] out_row[7:0] out_col[7:0] frame_end
// cfg       in         APB (psel..)   frame_rows @0x0, frame_cols @0x4, 11 bits each
//
// A pixel transfer is taken whenever the command queue has room.
// The back end reads and writes back the column sum for each pixel (IDLE, then ADD),
// and on a block end also runs the 16-step divider, then the output register (DIV, HOLD);
// it pops no new command from the queue before it is back in IDLE.
// Reset (rst_ni low, asynchronous) clears counters, queue and output valid;
// the column sum memory needs no clearing, as each block's first pixel writes it.
// A stalled result holds in the output register; the back end keeps going until its next result waits in HOLD.
module block_average_downscaler_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bdu_pixel_if.sink                         pix_i,
  bdu_result_if.source                      res_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdu_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bdu_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bdu_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [bdu_pkg::SIZE_W-1:0] frame_rows_q;
  logic [bdu_pkg::SIZE_W-1:0] frame_cols_q;
  logic                       cfg_write;
  logic [0:0]                 reg_sel;

  logic                       q_full, q_push, q_valid, q_pop;
  bdu_pkg::bdu_cmd_t          cmd_in, cmd_out;

  // Configuration: writes complete on the access cycle, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[bdu_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= bdu_pkg::SIZE_RESET;
      frame_cols_q <= bdu_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        bdu_pkg::REG_FRAME_ROWS: frame_rows_q <= pwdata[bdu_pkg::SIZE_W-1:0];
        bdu_pkg::REG_FRAME_COLS: frame_cols_q <= pwdata[bdu_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bdu_pkg::REG_FRAME_ROWS: prdata = bdu_pkg::APB_DATA_W'(frame_rows_q);
      bdu_pkg::REG_FRAME_COLS: prdata = bdu_pkg::APB_DATA_W'(frame_cols_q);
      default:                 prdata = '0;
    endcase
  end

  // Front: track raster position and classify each pixel into a command.
  bdu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pix_i),
    .frame_rows_i (frame_rows_q),
    .frame_cols_i (frame_cols_q),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .cmd_o        (cmd_in)
  );

  // Short queue decouples pixel intake from sum update and division.
  bdu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  // Back: accumulate block sums, divide on block end, drive the result.
  bdu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .res         (res_o)
  );

endmodule
